// ===== rtl/brb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants and helpers for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned MaxCapacity = 256;
  localparam int unsigned MaxBytes    = 8;
  localparam int unsigned PosW        = $clog2(MaxCapacity);
  localparam int unsigned CapW        = 9;
  localparam int unsigned LenW        = 4;
  localparam int unsigned IdxW        = $clog2(MaxBytes);
  localparam int unsigned DataW       = 8 * MaxBytes;

  // opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_NO_ROOM = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_NOTHING = 3'd4;

  // advance a ring position, wrapping at the capacity
  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] pos,
                                               input logic [CapW-1:0] cap);
    logic [CapW-1:0] inc;
    inc = CapW'(pos) + CapW'(1);
    if (inc >= cap) begin
      next_pos = '0;
    end else begin
      next_pos = inc[PosW-1:0];
    end
  endfunction

  // clamp a written capacity to 1..MaxCapacity
  function automatic logic [CapW-1:0] clamp_cap(input logic [CapW-1:0] value);
    if (value == '0) begin
      clamp_cap = CapW'(1);
    end else if (value > CapW'(MaxCapacity)) begin
      clamp_cap = CapW'(MaxCapacity);
    end else begin
      clamp_cap = value;
    end
  endfunction

endpackage

// ===== rtl/brb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/byte_ring_buffer_multi_byte_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_multi_byte_top
// Byte ring buffer of programmable capacity with push, pop and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the opcode (push, pop,
//   clear), tdata the byte count and up to eight push bytes. Each request
//   gives exactly one result on m_axis: tuser carries the status, tdata the
//   moved count, the popped bytes and the fill level after the request.
//   The capacity register is written through cfg_we_i / cfg_wdata_i; the user
//   writes it only while the block is idle, which the block itself does not enforce; a write also empties the ring.
// Operation:
//   Bytes move through one byte-wide RAM, one byte per cycle on its single
//   write or read port. A push writes its bytes in S_PUSH; a pop reads them
//   in S_POP and then waits for the registered RAM read data of the last byte.
//   A clear or a rejected request goes straight to S_DONE; every result waits
//   there until the output register frees.
// Reset and stall:
//   Reset empties the ring and sets the capacity to 256; no clearing pass.
//   A result waits in the output register while m_axis_tready is low; the
//   next request is still taken and its result holds back until the
//   output register frees.
// ----------------------------------------------------------------------------
module byte_ring_buffer_multi_byte_top
  import brb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,     // capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,    // [3:0] byte_count, [67:4] push_bytes, [71:68] zero
  input  logic [1:0]  s_axis_tuser,    // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,    // [3:0] moved_count, [67:4] pop_bytes,
                                       // [76:68] fill_level, [79:77] zero
  output logic [2:0]  m_axis_tuser     // [2:0] status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CapW-1:0]  cap_q, cap_d;
  logic [PosW-1:0]  wr_pos_q, wr_pos_d;
  logic [PosW-1:0]  rd_pos_q, rd_pos_d;
  logic [CapW-1:0]  held_q, held_d;
  logic [LenW-1:0]  left_q, left_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]  bidx_q, bidx_d;
  logic [DataW-1:0] data_q, data_d;
  logic [2:0]       res_status_q, res_status_d;
  logic [LenW-1:0]  res_moved_q, res_moved_d;
  logic [DataW-1:0] res_pop_q, res_pop_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_status_q;
  logic [LenW-1:0]  out_moved_q;
  logic [DataW-1:0] out_pop_q;
  logic [CapW-1:0]  out_fill_q;
  logic             out_load;

  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  logic [1:0]       in_op;
  logic [LenW-1:0]  in_len;
  logic [LenW-1:0]  pop_len;
  logic [DataW-1:0] in_bytes;
  logic             in_fire;

  assign in_op    = s_axis_tuser;
  assign in_len   = s_axis_tdata[3:0];
  assign in_bytes = s_axis_tdata[67:4];
  assign pop_len  = (in_len > LenW'(MaxBytes)) ? LenW'(MaxBytes) : in_len;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Pushes finish before any later pop is issued, so RAM write and read of
  // one entry never meet in the same cycle.
  assign ram_we = (state_q == S_PUSH);
  assign ram_re = (state_q == S_POP) && (left_q != '0);

  brb_ram #(
    .Width (8),
    .Depth (MaxCapacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos_q),
    .wdata_i (data_q[7:0]),
    .re_i    (ram_re),
    .raddr_i (rd_pos_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    wr_pos_d     = wr_pos_q;
    rd_pos_d     = rd_pos_q;
    held_d       = held_q;
    left_d       = left_q;
    rd_pend_d    = rd_pend_q;
    bidx_d       = bidx_q;
    data_d       = data_q;
    res_status_d = res_status_q;
    res_moved_d  = res_moved_q;
    res_pop_d    = res_pop_q;

    if (cfg_we_i) begin
      cap_d    = clamp_cap(cfg_wdata_i);
      wr_pos_d = '0;
      rd_pos_d = '0;
      held_d   = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_OK;
          res_moved_d  = '0;
          res_pop_d    = '0;
          data_d       = in_bytes;
          bidx_d       = '0;
          rd_pend_d    = 1'b0;
          state_d      = S_DONE;
          case (in_op)
            OP_PUSH: begin
              if (in_len == '0 || in_len > LenW'(MaxBytes) || CapW'(in_len) > cap_q) begin
                res_status_d = ST_BAD_LEN;
              end else if (cap_q - held_q < CapW'(in_len)) begin
                res_status_d = ST_NO_ROOM;
              end else begin
                res_moved_d = in_len;
                left_d      = in_len;
                held_d      = held_q + CapW'(in_len);
                state_d     = S_PUSH;
              end
            end
            OP_POP: begin
              if (held_q == '0 || pop_len == '0) begin
                res_status_d = ST_NOTHING;
              end else if (held_q < CapW'(pop_len)) begin
                res_status_d = ST_SHORT;
              end else begin
                res_moved_d = pop_len;
                left_d      = pop_len;
                held_d      = held_q - CapW'(pop_len);
                state_d     = S_POP;
              end
            end
            OP_CLEAR: begin
              wr_pos_d = '0;
              rd_pos_d = '0;
              held_d   = '0;
            end
            default: begin
              // unused opcode: report ok, leave the ring alone
            end
          endcase
        end
      end
      S_PUSH: begin
        // write one byte per cycle, then shift the next one down
        data_d   = data_q >> 8;
        wr_pos_d = next_pos(wr_pos_q, cap_q);
        left_d   = left_q - LenW'(1);
        if (left_q == LenW'(1)) begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        if (left_q != '0) begin
          rd_pos_d  = next_pos(rd_pos_q, cap_q);
          left_d    = left_q - LenW'(1);
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          state_d   = S_DONE;
        end
        if (rd_pend_q) begin
          for (int k = 0; k < int'(MaxBytes); k++) begin
            if (bidx_q == IdxW'(k)) begin
              res_pop_d[8*k +: 8] = ram_rdata;
            end
          end
          bidx_d = bidx_q + IdxW'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CapW'(MaxCapacity);
      wr_pos_q    <= '0;
      rd_pos_q    <= '0;
      held_q      <= '0;
      left_q      <= '0;
      rd_pend_q   <= 1'b0;
      bidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      wr_pos_q    <= wr_pos_d;
      rd_pos_q    <= rd_pos_d;
      held_q      <= held_d;
      left_q      <= left_d;
      rd_pend_q   <= rd_pend_d;
      bidx_q      <= bidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    res_status_q <= res_status_d;
    res_moved_q  <= res_moved_d;
    res_pop_q    <= res_pop_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_moved_q  <= res_moved_q;
      out_pop_q    <= res_pop_q;
      out_fill_q   <= held_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_fill_q, out_pop_q, out_moved_q};

  logic [CapW:0] ring_sum;
  logic [CapW:0] ring_wr;
  assign ring_sum = (CapW+1)'(rd_pos_q) + (CapW+1)'(held_q);
  assign ring_wr  = (ring_sum >= (CapW+1)'(cap_q)) ? ring_sum - (CapW+1)'(cap_q) : ring_sum;

`ifndef ASSERT_OFF
  a_held_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_q)
    else $error("fill level exceeds capacity");

  a_positions_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (ring_wr == (CapW+1)'(wr_pos_q)))
    else $error("write position does not match read position plus fill level");

  a_write_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CapW'(wr_pos_q) < cap_q))
    else $error("store write beyond capacity");

  a_pop_tail_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP && left_q == '0) |-> rd_pend_q)
    else $error("pop finishing without a read in flight");
`endif

endmodule

// ===== bench/tb_byte_ring_buffer_multi_byte_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_multi_byte_top
// Self-checking bench for the byte ring buffer. A behavioral ring model
// predicts status, moved count, popped bytes and fill level for every
// accepted request. Directed tests cover the empty ring, rejected lengths,
// full-width data and the capacity limits. Random phases then run mostly
// well-formed push/pop traffic at several capacities, under bursty requests
// and a stalling result consumer.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_multi_byte_top
  import brb_pkg::*;
();

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  moved;
    logic [63:0] popped;
    logic [8:0]  fill;
  } ring_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // [3:0] byte_count, [67:4] push_bytes
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // [3:0] moved_count, [67:4] pop_bytes,
                                    // [76:68] fill_level
  logic [2:0]  m_axis_tuser;        // [2:0] status

  // ring model state
  logic [7:0]      ring_mem [MaxCapacity];
  logic [PosW-1:0] wr_pos;
  logic [PosW-1:0] rd_pos;
  logic [CapW-1:0] held_bytes;
  logic [CapW-1:0] ring_cap;

  ring_result_t pending_results[$];
  int           err_cnt = 0;

  byte_ring_buffer_multi_byte_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [PosW-1:0] wrap_inc(input logic [PosW-1:0] p);
    int n;
    n = int'(p) + 1;
    if (n >= int'(ring_cap)) n = 0;
    return n[PosW-1:0];
  endfunction

  function automatic void empty_ring();
    wr_pos     = '0;
    rd_pos     = '0;
    held_bytes = '0;
  endfunction

  // Apply one request to the ring model and queue the result it should give.
  task automatic predict_ring(input logic [1:0] op, input logic [3:0] cnt,
                              input logic [63:0] data);
    ring_result_t r;
    int           len;
    r   = '0;
    len = int'(cnt);
    case (op)
      OP_PUSH: begin
        if (len == 0 || len > int'(MaxBytes) || len > int'(ring_cap)) begin
          r.status = ST_BAD_LEN;
        end else if (int'(ring_cap) - int'(held_bytes) < len) begin
          r.status = ST_NO_ROOM;
        end else begin
          for (int i = 0; i < len; i++) begin
            ring_mem[wr_pos] = data[8*i +: 8];
            wr_pos = wrap_inc(wr_pos);
          end
          held_bytes = held_bytes + CapW'(len);
          r.moved    = len[3:0];
        end
      end
      OP_POP: begin
        if (len > int'(MaxBytes)) len = int'(MaxBytes);
        if (held_bytes == '0 || len == 0) begin
          r.status = ST_NOTHING;
        end else if (int'(held_bytes) < len) begin
          r.status = ST_SHORT;
        end else begin
          for (int i = 0; i < len; i++) begin
            r.popped[8*i +: 8] = ring_mem[rd_pos];
            rd_pos = wrap_inc(rd_pos);
          end
          held_bytes = held_bytes - CapW'(len);
          r.moved    = len[3:0];
        end
      end
      OP_CLEAR: empty_ring();
      default: ;
    endcase
    r.fill = held_bytes;
    pending_results.push_back(r);
  endtask

  // Present one request and hold it until accepted; valid stays high.
  task automatic send_req(input logic [1:0] op, input logic [3:0] cnt,
                          input logic [63:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, data, cnt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_ring(op, cnt, data);
  endtask

  task automatic idle_gap(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off requests until every result is back, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [8:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (value == '0) ring_cap = CapW'(1);
    else if (int'(value) > int'(MaxCapacity)) ring_cap = CapW'(MaxCapacity);
    else ring_cap = value;
    empty_ring();
  endtask

  function automatic void report_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // result checker
  initial begin
    ring_result_t want;
    ring_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.moved  = m_axis_tdata[3:0];
        got.popped = m_axis_tdata[67:4];
        got.fill   = m_axis_tdata[76:68];
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, got);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          report_field("status", 64'(want.status), 64'(got.status));
          report_field("moved_count", 64'(want.moved), 64'(got.moved));
          report_field("pop_bytes", want.popped, got.popped);
          report_field("fill_level", 64'(want.fill), 64'(got.fill));
        end
      end
    end
  end

  // consumer back-pressure: switch between always ready, coin flip,
  // mostly stalled and long stall stretches
  initial begin
    int mode;
    int mode_left;
    int stall_left;
    mode_left  = 0;
    stall_left = 0;
    mode       = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  task automatic test_empty_and_bad_lengths();
    send_req(OP_POP, 4'd1, '0);
    send_req(OP_POP, 4'd0, '0);
    send_req(OP_PUSH, 4'd0, {$urandom, $urandom});
    send_req(OP_PUSH, 4'd9, {$urandom, $urandom});
    send_req(OP_PUSH, 4'd15, '1);
    send_req(OpUnused, 4'd15, '1);
    send_req(OP_CLEAR, 4'd0, '0);
  endtask

  task automatic test_full_width_bytes();
    send_req(OP_PUSH, 4'd8, '1);
    send_req(OP_PUSH, 4'd8, '0);
    send_req(OP_PUSH, 4'd1, 64'hA5);
    // pop lengths above eight saturate
    send_req(OP_POP, 4'd15, '0);
    send_req(OP_POP, 4'd9, '0);
    send_req(OP_POP, 4'd2, '0);
    send_req(OP_POP, 4'd1, '0);
    send_req(OP_POP, 4'd8, '0);
  endtask

  task automatic test_capacity_limits();
    // zero is taken as one byte
    set_capacity(9'd0);
    send_req(OP_PUSH, 4'd2, 64'h1234);
    send_req(OP_PUSH, 4'd1, 64'h5A);
    send_req(OP_PUSH, 4'd1, 64'h77);
    send_req(OP_POP, 4'd1, '0);
    send_req(OP_PUSH, 4'd1, 64'hC3);
    // wrap at a capacity of ten
    set_capacity(9'd10);
    send_req(OP_PUSH, 4'd8, {$urandom, $urandom});
    send_req(OP_PUSH, 4'd3, {$urandom, $urandom});
    send_req(OP_PUSH, 4'd2, {$urandom, $urandom});
    send_req(OP_POP, 4'd8, '0);
    send_req(OP_PUSH, 4'd5, {$urandom, $urandom});
    send_req(OP_POP, 4'd7, '0);
    send_req(OP_PUSH, 4'd4, {$urandom, $urandom});
    send_req(OP_CLEAR, 4'd0, '0);
    send_req(OP_POP, 4'd1, '0);
    // a capacity write drops held data; oversize is taken as the maximum
    send_req(OP_PUSH, 4'd3, {$urandom, $urandom});
    set_capacity(9'd511);
    send_req(OP_POP, 4'd1, '0);
  endtask

  task automatic run_random_phase(input logic [8:0] cap_value, input int n_items);
    int         burst_left;
    int         max_len;
    int         r;
    logic [1:0] op;
    logic [3:0] cnt;
    set_capacity(cap_value);
    burst_left = $urandom_range(1, 12);
    for (int k = 0; k < n_items; k++) begin
      // pause until the ring is fully settled mid-phase
      if (k == n_items / 2) drain();
      max_len = (int'(ring_cap) < int'(MaxBytes)) ? int'(ring_cap) : int'(MaxBytes);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        op  = 2'($urandom_range(0, 3));
        cnt = 4'($urandom_range(0, 15));
      end else if (r < 11) begin
        op  = OP_CLEAR;
        cnt = 4'($urandom_range(0, 15));
      end else if (r < 13) begin
        op  = OpUnused;
        cnt = 4'($urandom_range(0, 15));
      end else begin
        // lean toward pops when the ring is at least half full
        if ($urandom_range(0, 99) < ((int'(held_bytes) * 2 >= int'(ring_cap)) ? 35 : 65))
          op = OP_PUSH;
        else
          op = OP_POP;
        cnt = 4'($urandom_range(1, max_len));
      end
      send_req(op, cnt, {$urandom, $urandom});
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(9'd256, 140);
    run_random_phase(9'd1, 140);
    run_random_phase(9'd2, 140);
    run_random_phase(9'd8, 140);
    run_random_phase(9'd9, 140);
    run_random_phase(9'd13, 140);
    run_random_phase(9'($urandom_range(14, 255)), 140);
    run_random_phase(9'd511, 140);
    run_random_phase(9'd0, 140);
    run_random_phase(9'($urandom_range(257, 510)), 140);
  endtask

  initial begin
    for (int i = 0; i < int'(MaxCapacity); i++) ring_mem[i] = '0;
    ring_cap = CapW'(MaxCapacity);
    empty_ring();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_bad_lengths();
    test_full_width_bytes();
    test_capacity_limits();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/byte_ring_buffer_multi_byte_top.sv
bench/tb_byte_ring_buffer_multi_byte_top.sv
